// ----- rtl/alcp_pkg.sv -----
`timescale 1ns / 1ps

package alcp_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int CMD_LEN        = 8;
	localparam int PC_W           = 6;

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Microprogram entry points
	localparam logic [PC_W-1:0] PC_IDLE   = 6'd0;
	localparam logic [PC_W-1:0] PC_BS     = 6'd4;
	localparam logic [PC_W-1:0] PC_CR     = 6'd5;
	localparam logic [PC_W-1:0] PC_SCAN   = 6'd6;
	localparam logic [PC_W-1:0] PC_RESP   = 6'd8;
	localparam logic [PC_W-1:0] PC_OK_ON  = 6'd10;
	localparam logic [PC_W-1:0] PC_OFFCHK = 6'd16;
	localparam logic [PC_W-1:0] PC_OK_OFF = 6'd18;
	localparam logic [PC_W-1:0] PC_ERRCHK = 6'd24;
	localparam logic [PC_W-1:0] PC_ERR    = 6'd25;
	localparam logic [PC_W-1:0] PC_ECHO   = 6'd34;

	typedef enum logic [2:0] {
		COND_NEVER     = 3'd0,
		COND_ALWAYS    = 3'd1,
		COND_IS_BS     = 3'd2,
		COND_IS_CR     = 3'd3,
		COND_SCAN_DONE = 3'd4,
		COND_NOT_ON    = 3'd5,
		COND_NOT_OFF   = 3'd6,
		COND_ANY_OK    = 3'd7
	} cond_t;

	typedef enum logic [3:0] {
		ACT_NOP       = 4'd0,
		ACT_LATCH     = 4'd1,
		ACT_STORE     = 4'd2,
		ACT_DEC       = 4'd3,
		ACT_SCAN_INIT = 4'd4,
		ACT_CMP       = 4'd5,
		ACT_LED_ON    = 4'd6,
		ACT_LED_OFF   = 4'd7,
		ACT_CLEAR     = 4'd8
	} act_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_LIT  = 2'd1,
		SRC_ECHO = 2'd2
	} src_t;

	typedef struct packed {
		logic            wait_in;
		cond_t           cond;
		logic [PC_W-1:0] target;
		act_t            act;
		src_t            src;
		logic            last;
		logic [7:0]      lit;
	} ucw_t;

	typedef struct packed {
		logic       fire;
		logic       wait_in;
		act_t       act;
		src_t       src;
		logic       last;
		logic [7:0] lit;
	} ctl_t;

	typedef struct packed {
		logic is_bs;
		logic is_cr;
		logic scan_done;
		logic on_ok;
		logic off_ok;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] cmd_char(input logic [2:0] pos, input logic on);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h41; // A
			3'd1:    c = 8'h54; // T
			3'd2:    c = 8'h2B; // +
			3'd3:    c = 8'h4C; // L
			3'd4:    c = 8'h45; // E
			3'd5:    c = 8'h44; // D
			3'd6:    c = 8'h3D; // =
			default: c = on ? 8'h31 : 8'h30;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ok_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CH_CR;
			3'd1:    c = CH_LF;
			3'd2:    c = 8'h4F; // O
			3'd3:    c = 8'h4B; // K
			3'd4:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] err_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = CH_CR;
			4'd1:    c = CH_LF;
			4'd2:    c = 8'h45; // E
			4'd3:    c = 8'h52; // R
			4'd4:    c = 8'h52; // R
			4'd5:    c = 8'h4F; // O
			4'd6:    c = 8'h52; // R
			4'd7:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	function automatic ucw_t uc_step(input act_t act, input cond_t cond,
		input logic [PC_W-1:0] target);
		ucw_t w;
		w.wait_in = 1'b0;
		w.cond    = cond;
		w.target  = target;
		w.act     = act;
		w.src     = SRC_NONE;
		w.last    = 1'b0;
		w.lit     = 8'h00;
		return w;
	endfunction

	function automatic ucw_t uc_emit(input logic [7:0] lit);
		ucw_t w;
		w     = uc_step(ACT_NOP, COND_NEVER, PC_IDLE);
		w.src = SRC_LIT;
		w.lit = lit;
		return w;
	endfunction

	// Control store
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = uc_step(ACT_NOP, COND_ALWAYS, PC_IDLE);
		case (pc) inside
			PC_IDLE: begin
				w         = uc_step(ACT_LATCH, COND_NEVER, PC_IDLE);
				w.wait_in = 1'b1;
			end
			6'd1:      w = uc_step(ACT_NOP, COND_IS_BS, PC_BS);
			6'd2:      w = uc_step(ACT_NOP, COND_IS_CR, PC_CR);
			6'd3:      w = uc_step(ACT_STORE, COND_ALWAYS, PC_ECHO);
			PC_BS:     w = uc_step(ACT_DEC, COND_ALWAYS, PC_ECHO);
			PC_CR:     w = uc_step(ACT_SCAN_INIT, COND_NEVER, PC_IDLE);
			PC_SCAN:   w = uc_step(ACT_NOP, COND_SCAN_DONE, PC_RESP);
			6'd7:      w = uc_step(ACT_CMP, COND_ALWAYS, PC_SCAN);
			PC_RESP:   w = uc_step(ACT_NOP, COND_NOT_ON, PC_OFFCHK);
			6'd9:      w = uc_step(ACT_LED_ON, COND_NEVER, PC_IDLE);
			[6'd10:6'd15]: w = uc_emit(ok_char(3'(pc - PC_OK_ON)));
			PC_OFFCHK: w = uc_step(ACT_NOP, COND_NOT_OFF, PC_ERRCHK);
			6'd17:     w = uc_step(ACT_LED_OFF, COND_NEVER, PC_IDLE);
			[6'd18:6'd23]: w = uc_emit(ok_char(3'(pc - PC_OK_OFF)));
			PC_ERRCHK: w = uc_step(ACT_CLEAR, COND_ANY_OK, PC_ECHO);
			[6'd25:6'd33]: w = uc_emit(err_char(4'(pc - PC_ERR)));
			PC_ECHO: begin
				w      = uc_step(ACT_NOP, COND_ALWAYS, PC_IDLE);
				w.src  = SRC_ECHO;
				w.last = 1'b1;
			end
			default:   w = uc_step(ACT_NOP, COND_ALWAYS, PC_IDLE);
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/alcp_if.sv -----
`timescale 1ns / 1ps

interface alcp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface alcp_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       led_state;
	logic       last;

	modport source (output valid, output tx_byte, output led_state, output last, input ready);
	modport sink (input valid, input tx_byte, input led_state, input last, output ready);
endinterface

// ----- rtl/at_led_command_line_parser_top.sv -----
`timescale 1ns / 1ps

// AT LED command line parser. Received bytes enter on rx, one transaction each;
// every byte produces a burst of tx transactions that ends with its echo (last = 1).
// Backspace drops the last stored character, carriage return checks the stored line
// against AT+LED=1 and AT+LED=0 (any prefix matches, so an empty line matches both)
// and answers CR LF OK CR LF per match, LED on first then off, or CR LF ERROR CR LF.
// led_state on each result is the LED drive after that byte. Characters past
// LINE_DEPTH are dropped but still echoed. Control is a microprogram of 35
// control words stepped one per cycle, except that a step holds while it waits
// for input or while the output register is still full under tx back-pressure.
// A carriage return compares at most 10 stored characters through the single
// buffer read port.
// The line buffer needs no clearing after reset; only stored entries are read.
module at_led_command_line_parser_top #(
	parameter int LINE_DEPTH = alcp_pkg::LINE_DEPTH_DEF
) (
	input logic     clk,
	input logic     arst_n,
	alcp_rx_if.sink   rx,
	alcp_tx_if.source tx
);
	import alcp_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// input is taken only at the idle step of the microprogram
	assign rx.ready = ctl.wait_in;

	alcp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: line buffer, length, compare flags, LED, output register
	alcp_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rx_byte   (rx.rx_byte),
		.out_ready (tx.ready),
		.sts       (sts),
		.out_valid (tx.valid),
		.tx_byte   (tx.tx_byte),
		.led_state (tx.led_state),
		.last      (tx.last)
	);

endmodule

// ----- rtl/alcp_seq.sv -----
`timescale 1ns / 1ps

module alcp_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  alcp_pkg::sts_t sts,
	output alcp_pkg::ctl_t ctl
);
	import alcp_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucw_t            cw;
	logic            stall;
	logic            take;

	assign cw = ucode(pc_q);

	// hold on missing input or a full output slot
	assign stall = (cw.wait_in && !in_valid) || ((cw.src != SRC_NONE) && !sts.out_free);

	always_comb begin
		case (cw.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_IS_BS:     take = sts.is_bs;
			COND_IS_CR:     take = sts.is_cr;
			COND_SCAN_DONE: take = sts.scan_done;
			COND_NOT_ON:    take = !sts.on_ok;
			COND_NOT_OFF:   take = !sts.off_ok;
			COND_ANY_OK:    take = sts.on_ok || sts.off_ok;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (!stall) begin
			pc_q <= take ? cw.target : pc_q + 6'd1;
		end
	end

	assign ctl.fire    = !stall;
	assign ctl.wait_in = cw.wait_in;
	assign ctl.act     = cw.act;
	assign ctl.src     = cw.src;
	assign ctl.last    = cw.last;
	assign ctl.lit     = cw.lit;

endmodule

// ----- rtl/alcp_dp.sv -----
`timescale 1ns / 1ps

module alcp_dp #(
	parameter int LINE_DEPTH = alcp_pkg::LINE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  alcp_pkg::ctl_t ctl,
	input  logic [7:0]     rx_byte,
	input  logic           out_ready,
	output alcp_pkg::sts_t sts,
	output logic           out_valid,
	output logic [7:0]     tx_byte,
	output logic           led_state,
	output logic           last
);
	import alcp_pkg::*;

	localparam int IW = $clog2(LINE_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH + 1);

	logic [7:0]    mem [LINE_DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    rx_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;
	logic          on_q;
	logic          off_q;
	logic          led_q;
	logic          ovalid_q;
	logic [7:0]    obyte_q;
	logic          oled_q;
	logic          olast_q;

	logic          wr_en;
	logic          in_cmd;
	logic          at_nul;
	logic          hit_on;
	logic          hit_off;
	logic [7:0]    exp_on;
	logic [7:0]    exp_off;
	logic          do_emit;

	assign wr_en   = ctl.fire && (ctl.act == ACT_STORE) && (len_q < LW'(LINE_DEPTH));
	assign do_emit = ctl.fire && (ctl.src != SRC_NONE);

	// line positions past the command compare with NUL, then always miss
	assign in_cmd  = idx_q < LW'(CMD_LEN);
	assign at_nul  = idx_q == LW'(CMD_LEN);
	assign exp_on  = in_cmd ? cmd_char(idx_q[2:0], 1'b1) : 8'h00;
	assign exp_off = in_cmd ? cmd_char(idx_q[2:0], 1'b0) : 8'h00;
	assign hit_on  = (in_cmd || at_nul) && (rd_q == exp_on);
	assign hit_off = (in_cmd || at_nul) && (rd_q == exp_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[len_q[IW-1:0]] <= rx_q;
		end
		rd_q <= mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && (ctl.act == ACT_LATCH)) begin
			rx_q <= rx_byte;
		end
		if (do_emit) begin
			obyte_q <= (ctl.src == SRC_ECHO) ? rx_q : ctl.lit;
			oled_q  <= led_q;
			olast_q <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
			on_q  <= 1'b0;
			off_q <= 1'b0;
			led_q <= 1'b0;
		end else if (ctl.fire) begin
			case (ctl.act)
				ACT_STORE: begin
					if (len_q < LW'(LINE_DEPTH)) begin
						len_q <= len_q + LW'(1);
					end
				end
				ACT_DEC: begin
					if (len_q != '0) begin
						len_q <= len_q - LW'(1);
					end
				end
				ACT_SCAN_INIT: begin
					idx_q <= '0;
					on_q  <= 1'b1;
					off_q <= 1'b1;
				end
				ACT_CMP: begin
					idx_q <= idx_q + LW'(1);
					on_q  <= on_q && hit_on;
					off_q <= off_q && hit_off;
				end
				ACT_LED_ON:  led_q <= 1'b1;
				ACT_LED_OFF: led_q <= 1'b0;
				ACT_CLEAR:   len_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (do_emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign sts.is_bs     = rx_q == CH_BS;
	assign sts.is_cr     = rx_q == CH_CR;
	assign sts.scan_done = (idx_q == len_q) || (!on_q && !off_q);
	assign sts.on_ok     = on_q;
	assign sts.off_ok    = off_q;
	assign sts.out_free  = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign tx_byte   = obyte_q;
	assign led_state = oled_q;
	assign last      = olast_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(LINE_DEPTH))
		else $error("line length beyond buffer depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		do_emit |-> (!ovalid_q || out_ready))
		else $error("emit over a pending transaction");

	a_cmp_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fire && ctl.act == ACT_CMP) |-> (idx_q < len_q))
		else $error("compare beyond stored line");

	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.fire && (ctl.act == ACT_LED_ON || ctl.act == ACT_LED_OFF)) |=> $stable(led_q))
		else $error("LED changed outside a command");

endmodule

// ----- test/alcp_reply_check.sv -----
`timescale 1ns / 1ps

module alcp_reply_check #(
	parameter int LINE_DEPTH = alcp_pkg::LINE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	alcp_rx_if   rx,
	alcp_tx_if   tx,
	output int   mismatches,
	output int   pending,
	output int   checked,
	output int   ok_replies,
	output int   err_replies
);
	import alcp_pkg::*;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       led_state;
		logic       last;
	} tx_beat_t;

	localparam logic [7:0] CMD_STEM [7] = '{"A", "T", "+", "L", "E", "D", "="};
	localparam logic [7:0] OK_TEXT [6] = '{CH_CR, CH_LF, "O", "K", CH_CR, CH_LF};
	localparam logic [7:0] ERR_TEXT [9] =
		'{CH_CR, CH_LF, "E", "R", "R", "O", "R", CH_CR, CH_LF};

	logic [7:0] line_text [LINE_DEPTH];
	int         line_len;
	logic       led;
	tx_beat_t   tx_due [$];

	// prefix match; position 8 must hold NUL, anything past it fails
	function automatic logic line_fits(input logic on);
		logic [7:0] want;
		for (int i = 0; i < line_len; i++) begin
			if (i < CMD_LEN - 1)
				want = CMD_STEM[i];
			else if (i == CMD_LEN - 1)
				want = on ? "1" : "0";
			else if (i == CMD_LEN)
				want = 8'h00;
			else
				return 1'b0;
			if (line_text[i] != want)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void add_beat(input logic [7:0] b, input logic is_last);
		tx_beat_t beat;
		beat.tx_byte   = b;
		beat.led_state = led;
		beat.last      = is_last;
		tx_due.push_back(beat);
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		logic on_hit;
		logic off_hit;
		if (b == CH_BS) begin
			if (line_len > 0)
				line_len--;
		end else if (b == CH_CR) begin
			on_hit  = line_fits(1'b1);
			off_hit = line_fits(1'b0);
			if (on_hit) begin
				led = 1'b1;
				foreach (OK_TEXT[i]) add_beat(OK_TEXT[i], 1'b0);
				ok_replies++;
			end
			if (off_hit) begin
				led = 1'b0;
				foreach (OK_TEXT[i]) add_beat(OK_TEXT[i], 1'b0);
				ok_replies++;
			end
			if (!on_hit && !off_hit) begin
				foreach (ERR_TEXT[i]) add_beat(ERR_TEXT[i], 1'b0);
				err_replies++;
			end
			line_len = 0;
		end else if (line_len < LINE_DEPTH) begin
			line_text[line_len] = b;
			line_len++;
		end
		add_beat(b, 1'b1);
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tx_beat_t want;
		if (!arst_n) begin
			line_len    = 0;
			led         = 1'b0;
			mismatches  = 0;
			checked     = 0;
			ok_replies  = 0;
			err_replies = 0;
			tx_due.delete();
		end else begin
			if (rx.valid && rx.ready)
				take_byte(rx.rx_byte);
			if (tx.valid && tx.ready) begin
				checked++;
				if (tx_due.size() == 0) begin
					mismatches++;
					$display("%0t: tx byte %h (led %b last %b) with nothing expected",
						$time, tx.tx_byte, tx.led_state, tx.last);
				end else begin
					want = tx_due.pop_front();
					check_field("tx_byte", want.tx_byte, tx.tx_byte);
					check_field("led_state", 8'(want.led_state), 8'(tx.led_state));
					check_field("last", 8'(want.last), 8'(tx.last));
				end
			end
		end
		pending = tx_due.size();
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the AT LED line parser. The reply checker beside the
// block tracks the line and LED, predicts every tx transaction and counts
// mismatches; this module only feeds bytes, throttles tx and decides.
module tb;
	import alcp_pkg::*;

	localparam int DEPTH        = LINE_DEPTH_DEF;
	localparam int BYTE_TARGET  = 430;
	// A carriage return's reply is bounded apart from tx stalls; STALL_LIMIT quiet
	// cycles is far past any legal gap between two transactions.
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic calm;
	int   sent;
	int   lines;
	int   overflows;
	int   quiet_cycles = 0;
	int   mismatches;
	int   outstanding;
	int   checked;
	int   ok_replies;
	int   err_replies;

	alcp_rx_if rx_ch ();
	alcp_tx_if tx_ch ();

	at_led_command_line_parser_top #(.LINE_DEPTH(DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.tx    (tx_ch)
	);

	alcp_reply_check #(.LINE_DEPTH(DEPTH)) reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.tx         (tx_ch),
		.mismatches (mismatches),
		.pending    (outstanding),
		.checked    (checked),
		.ok_replies (ok_replies),
		.err_replies(err_replies)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// tx back-pressure: ready drops about 16% of cycles, never during the calm window
	always @(posedge clk) begin
		tx_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
	end

	// watchdog: any cycle without a transaction on either side counts
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d tx bytes still expected",
				$time, STALL_LIMIT, outstanding);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Any byte except CR and BS, so it lands in the line buffer.
	function automatic logic [7:0] rand_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_BS);
		return b;
	endfunction

	// One rx transaction. Sometimes idle first, for a random length, so valid
	// rises at different points of the block's microprogram. valid stays high
	// from one byte to the next when there is no idle.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		calm <= (sent >= 150 && sent < 260);
		if (!(sent >= 150 && sent < 260) && $urandom_range(0, 99) < 16) begin
			gap = $urandom_range(1, 12);
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		sent++;
		if (b == CH_CR)
			lines++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Plain characters then CR; lengths past DEPTH hit the full-buffer drop.
	task automatic junk_line(input int n);
		if (n > DEPTH)
			overflows++;
		for (int i = 0; i < n; i++)
			send_byte(rand_plain());
		send_byte(CH_CR);
	endtask

	// Well-formed command lines (the largest share) with random edits and tails, then
	// corrupted commands, long lines, short garbage and raw noise.
	task automatic random_line();
		int    kind;
		int    n;
		int    cut;
		string cmd;
		kind = $urandom_range(0, 99);
		cmd  = $urandom_range(0, 1) ? "AT+LED=1" : "AT+LED=0";
		if (kind < 40) begin
			// full command or prefix; typo+backspace edits; NUL or stray tail
			n = (kind < 28) ? CMD_LEN : $urandom_range(0, CMD_LEN);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 12) begin
					send_byte(rand_plain());
					send_byte(CH_BS);
				end
				send_byte(cmd[i]);
			end
			if (n == CMD_LEN && $urandom_range(0, 99) < 30)
				send_byte(8'h00);
			if ($urandom_range(0, 99) < 12)
				send_byte(rand_plain());
			send_byte(CH_CR);
		end else if (kind < 55) begin
			cut = $urandom_range(0, CMD_LEN - 1);
			for (int i = 0; i < CMD_LEN; i++)
				send_byte(i == cut ? rand_plain() : cmd[i]);
			send_byte(CH_CR);
		end else if (kind < 63) begin
			junk_line($urandom_range(30, 40));
		end else if (kind < 82) begin
			// short garbage, backspace-heavy (walks past an empty line)
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				send_byte($urandom_range(0, 3) == 0 ? CH_BS : 8'($urandom_range(0, 255)));
			send_byte(CH_CR);
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		calm          <= 1'b0;
		sent      = 0;
		lines     = 0;
		overflows = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: backspace on empty line, empty line (both OKs, on then off),
		// both commands, extreme bytes as bad lines, NUL in the slot after a command
		send_byte(CH_BS);
		send_byte(CH_CR);
		send_text("AT+LED=1");
		send_byte(CH_CR);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(8'h00);
		send_byte(CH_CR);
		send_text("AT+LED=0");
		send_byte(8'h00);
		send_byte(CH_CR);

		// random: one guaranteed over-capacity line, then mixed traffic
		junk_line(DEPTH + 4);
		while (sent < BYTE_TARGET)
			random_line();

		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d lines, %0d of them over the %0d-char buffer",
			sent, lines, overflows, DEPTH);
		$display("Checked %0d tx bytes carrying %0d OK and %0d ERROR replies",
			checked, ok_replies, err_replies);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
